[rtl/pmvf_pkg.sv]
`default_nettype none
package pmvf_pkg;

   localparam int NUM_PARTICLES = 32;
   localparam int DIMS          = 3;

   localparam int VEC_WORDS = NUM_PARTICLES * DIMS;
   localparam int ROW_BLOCK = DIMS * VEC_WORDS;
   localparam int MAT_WORDS = NUM_PARTICLES * ROW_BLOCK;
   localparam int VEC_AW    = (VEC_WORDS > 1) ? $clog2(VEC_WORDS) : 1;
   localparam int MAT_AW    = (MAT_WORDS > 1) ? $clog2(MAT_WORDS) : 1;

   // The result always carries three force components.
   localparam int OUT_DIMS = 3;
   localparam int DIM_W    = 2;

   localparam logic [1:0] OP_MAT_WR = 2'd0;
   localparam logic [1:0] OP_VEC_WR = 2'd1;
   localparam logic [1:0] OP_FORCE  = 2'd2;

   // Register index as seen on paddr[2].
   localparam logic CSR_IDX_FACTOR = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_SCALE,
      ST_ADD
   } state_type;

   typedef struct packed {
      logic             item_load;
      logic             rd_en;
      logic             acc_clr;
      logic             sat_load;
      logic             scale_sel;
      logic             add_en;
      logic             add_active;
      logic [DIM_W-1:0] dim;
   } ctl_type;

endpackage
`default_nettype wire

[rtl/particle_matrix_vector_force.sv]
`default_nettype none
// Channel   Handshake              Payload
// request   start, busy            req_opcode, req_store_address, req_store_value,
//                                  req_particle, req_old_force_x/y/z
// result    rsp_valid (strobe)     rsp_new_force_x/y/z, rsp_saturated
// config    psel, penable, pwrite  paddr, pwdata, prdata, pready (always high)
//
// Matrix and vector writes can follow each other every cycle while busy is low.
// A force item keeps busy high through all three components; when the particle is in
// range, each component streams its row through the single multiplier and one read port
// per store, then reuses that multiplier for the scaling step.
// The result strobe appears in the same cycle that busy falls and lasts one cycle; it cannot
// be stalled. Reset is synchronous; the stores are not cleared and need no clearing pass.
module particle_matrix_vector_force import pmvf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [13:0]        req_store_address,
   input  logic signed [31:0] req_store_value,
   input  logic [4:0]         req_particle,
   input  logic signed [31:0] req_old_force_x,
   input  logic signed [31:0] req_old_force_y,
   input  logic signed [31:0] req_old_force_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_new_force_x,
   output logic signed [31:0] rsp_new_force_y,
   output logic signed [31:0] rsp_new_force_z,
   output logic               rsp_saturated,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam logic [31:0] FACTOR_RESET = 32'h0001_0000;

   logic [31:0]       factor_ff;
   logic              accept;
   logic              factor_we;
   ctl_type           ctl;
   logic [MAT_AW-1:0] rd_mat_addr;
   logic [VEC_AW-1:0] rd_vec_addr;
   logic [31:0]       mat_q;
   logic [31:0]       vec_q;
   logic              q_vld;

   assign pready    = 1'b1;
   assign accept    = start && !busy;
   assign factor_we = psel && penable && pwrite && pready && (paddr[2] == CSR_IDX_FACTOR);
   assign prdata    = (paddr[2] == CSR_IDX_FACTOR) ? factor_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
      end else if (factor_we) begin
         factor_ff <= pwdata;
      end
   end

   pmvf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .opcode      (req_opcode),
      .particle    (req_particle),
      .busy        (busy),
      .ctl         (ctl),
      .rd_mat_addr (rd_mat_addr),
      .rd_vec_addr (rd_vec_addr),
      .rsp_valid   (rsp_valid)
   );

   pmvf_store u_store (
      .clock       (clock),
      .reset       (reset),
      .wr_accept   (accept),
      .wr_opcode   (req_opcode),
      .wr_address  (req_store_address),
      .wr_value    (req_store_value),
      .rd_en       (ctl.rd_en),
      .rd_mat_addr (rd_mat_addr),
      .rd_vec_addr (rd_vec_addr),
      .mat_q       (mat_q),
      .vec_q       (vec_q),
      .q_vld       (q_vld)
   );

   pmvf_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .mat_q     (mat_q),
      .vec_q     (vec_q),
      .q_vld     (q_vld),
      .factor    (factor_ff),
      .old_x     (req_old_force_x),
      .old_y     (req_old_force_y),
      .old_z     (req_old_force_z),
      .new_x     (rsp_new_force_x),
      .new_y     (rsp_new_force_y),
      .new_z     (rsp_new_force_z),
      .saturated (rsp_saturated)
   );

endmodule
`default_nettype wire

[rtl/pmvf_store.sv]
`default_nettype none
module pmvf_store import pmvf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_accept,
   input  logic [1:0]        wr_opcode,
   input  logic [13:0]       wr_address,
   input  logic [31:0]       wr_value,
   input  logic              rd_en,
   input  logic [MAT_AW-1:0] rd_mat_addr,
   input  logic [VEC_AW-1:0] rd_vec_addr,
   output logic [31:0]       mat_q,
   output logic [31:0]       vec_q,
   output logic              q_vld
);

   logic [31:0] mat_mem [MAT_WORDS];
   logic [31:0] vec_mem [VEC_WORDS];

   logic [31:0] mat_q_ff;
   logic [31:0] vec_q_ff;
   logic        q_vld_ff;
   logic        mat_we;
   logic        vec_we;

   // Writes beyond the end of a store are dropped.
   assign mat_we = wr_accept && (wr_opcode == OP_MAT_WR) && (32'(wr_address) < MAT_WORDS);
   assign vec_we = wr_accept && (wr_opcode == OP_VEC_WR) && (32'(wr_address) < VEC_WORDS);

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[MAT_AW'(wr_address)] <= wr_value;
      end
      if (vec_we) begin
         vec_mem[VEC_AW'(wr_address)] <= wr_value;
      end
      if (rd_en) begin
         mat_q_ff <= mat_mem[rd_mat_addr];
         vec_q_ff <= vec_mem[rd_vec_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else begin
         q_vld_ff <= rd_en;
      end
   end

   assign mat_q = mat_q_ff;
   assign vec_q = vec_q_ff;
   assign q_vld = q_vld_ff;

endmodule
`default_nettype wire

[rtl/pmvf_mac.sv]
`default_nettype none
module pmvf_mac import pmvf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   input  logic signed [31:0] mat_q,
   input  logic signed [31:0] vec_q,
   input  logic               q_vld,
   input  logic signed [31:0] factor,
   input  logic signed [31:0] old_x,
   input  logic signed [31:0] old_y,
   input  logic signed [31:0] old_z,
   output logic signed [31:0] new_x,
   output logic signed [31:0] new_y,
   output logic signed [31:0] new_z,
   output logic               saturated
);

   localparam logic signed [63:0] ACC_MAX = 64'sd2147483647;
   localparam logic signed [63:0] ACC_MIN = -64'sd2147483648;
   localparam logic signed [48:0] SUM_MAX = 49'sd2147483647;
   localparam logic signed [48:0] SUM_MIN = -49'sd2147483648;

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic               prod_vld_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] sum_sat_ff;
   logic signed [31:0] old_ff [OUT_DIMS];
   logic signed [31:0] new_ff [OUT_DIMS];
   logic               clip_ff;

   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [47:0] prod_shr;
   logic               acc_hi;
   logic               acc_lo;
   logic signed [31:0] acc_sat;
   logic signed [48:0] add_sum;
   logic               add_hi;
   logic               add_lo;
   logic signed [31:0] add_sat;

   // The one multiplier serves the dot product and then the scaling by the factor.
   assign mul_a   = ctl.scale_sel ? sum_sat_ff : mat_q;
   assign mul_b   = ctl.scale_sel ? factor : vec_q;
   assign prod_in = mul_a * mul_b;

   // An arithmetic shift of the exact product rounds toward minus infinity.
   assign prod_shr = prod_ff[63:16];

   assign acc_hi  = acc_ff > ACC_MAX;
   assign acc_lo  = acc_ff < ACC_MIN;
   assign acc_sat = acc_hi ? 32'sh7FFFFFFF : (acc_lo ? 32'sh80000000 : acc_ff[31:0]);

   assign add_sum = {{17{old_ff[ctl.dim][31]}}, old_ff[ctl.dim]}
                  + (ctl.add_active ? {prod_shr[47], prod_shr} : 49'sd0);
   assign add_hi  = add_sum > SUM_MAX;
   assign add_lo  = add_sum < SUM_MIN;
   assign add_sat = add_hi ? 32'sh7FFFFFFF : (add_lo ? 32'sh80000000 : add_sum[31:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= q_vld;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl.acc_clr) begin
         acc_ff <= 64'sd0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff - {{16{prod_shr[47]}}, prod_shr};
      end
      if (ctl.sat_load) begin
         sum_sat_ff <= acc_sat;
      end
      if (ctl.item_load) begin
         old_ff[0] <= old_x;
         old_ff[1] <= old_y;
         old_ff[2] <= old_z;
      end
      if (ctl.add_en) begin
         new_ff[ctl.dim] <= add_sat;
      end
      if (ctl.item_load) begin
         clip_ff <= 1'b0;
      end else if (ctl.sat_load) begin
         clip_ff <= clip_ff | acc_hi | acc_lo;
      end else if (ctl.add_en) begin
         clip_ff <= clip_ff | add_hi | add_lo;
      end
   end

   assign new_x     = new_ff[0];
   assign new_y     = new_ff[1];
   assign new_z     = new_ff[2];
   assign saturated = clip_ff;

endmodule
`default_nettype wire

[rtl/pmvf_ctrl.sv]
`default_nettype none
module pmvf_ctrl import pmvf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        opcode,
   input  logic [4:0]        particle,
   output logic              busy,
   output ctl_type           ctl,
   output logic [MAT_AW-1:0] rd_mat_addr,
   output logic [VEC_AW-1:0] rd_vec_addr,
   output logic              rsp_valid
);

   localparam logic [VEC_AW-1:0] ROW_LAST   = VEC_AW'(VEC_WORDS - 1);
   localparam logic [1:0]        DRAIN_LAST = 2'd2;
   localparam logic [DIM_W-1:0]  DIM_LAST   = DIM_W'(OUT_DIMS - 1);

   state_type         state_ff;
   state_type         state_in;
   logic [DIM_W-1:0]  dim_ff;
   logic [VEC_AW-1:0] idx_ff;
   logic [MAT_AW-1:0] mat_addr_ff;
   logic [1:0]        drain_ff;
   logic              part_ok_ff;
   logic              rsp_valid_ff;

   logic              force_accept;
   logic              part_ok_in;
   logic              dim_active;
   logic              next_active;

   assign force_accept = start && (state_ff == ST_IDLE) && (opcode == OP_FORCE);
   assign part_ok_in   = int'(particle) < NUM_PARTICLES;
   assign dim_active   = part_ok_ff && (int'(dim_ff) < DIMS);
   assign next_active  = part_ok_ff && ((int'(dim_ff) + 1) < DIMS);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (force_accept) begin
               state_in = part_ok_in ? ST_ISSUE : ST_ADD;
            end
         end
         ST_ISSUE: begin
            if (idx_ff == ROW_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (dim_ff == DIM_LAST) begin
               state_in = ST_IDLE;
            end else begin
               state_in = next_active ? ST_ISSUE : ST_ADD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl            = '0;
      ctl.item_load  = force_accept;
      ctl.rd_en      = state_ff == ST_ISSUE;
      ctl.acc_clr    = (state_ff == ST_IDLE) || (state_ff == ST_ADD);
      ctl.sat_load   = (state_ff == ST_DRAIN) && (drain_ff == DRAIN_LAST);
      ctl.scale_sel  = state_ff == ST_SCALE;
      ctl.add_en     = state_ff == ST_ADD;
      ctl.add_active = dim_active;
      ctl.dim        = dim_ff;
      busy           = state_ff != ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_ADD) && (dim_ff == DIM_LAST);
      end
   end

   // Rows of one particle lie back to back, so the matrix address just keeps counting.
   always_ff @(posedge clock) begin
      if (force_accept) begin
         dim_ff      <= '0;
         idx_ff      <= '0;
         drain_ff    <= '0;
         part_ok_ff  <= part_ok_in;
         mat_addr_ff <= MAT_AW'(int'(particle) * ROW_BLOCK);
      end
      if (state_ff == ST_ISSUE) begin
         idx_ff      <= (idx_ff == ROW_LAST) ? '0 : idx_ff + 1'b1;
         mat_addr_ff <= mat_addr_ff + 1'b1;
         drain_ff    <= '0;
      end
      if (state_ff == ST_DRAIN) begin
         drain_ff <= drain_ff + 1'b1;
      end
      if (state_ff == ST_ADD) begin
         dim_ff <= dim_ff + 1'b1;
      end
   end

   assign rd_mat_addr = mat_addr_ff;
   assign rd_vec_addr = idx_ff;
   assign rsp_valid   = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/pmvf_checker.sv]
`default_nettype none
module pmvf_checker import pmvf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid
);

   // A force item must make the block busy in the next cycle.
   a_force_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == OP_FORCE)) |=> busy)
      else $error("force item did not start a computation");

   // Store writes and unused opcodes never start work or produce a result.
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode != OP_FORCE)) |=> (!busy && !rsp_valid))
      else $error("non-compute item caused activity");

   // The end of a computation always produces its result.
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("computation finished without a result");

   // A result strobe shows only when idle and never twice in a row.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

endmodule

bind particle_matrix_vector_force pmvf_checker u_pmvf_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .rsp_valid  (rsp_valid)
);
`default_nettype wire
